FILE: rtl/sha256d_nonce_check_unit_assert.svh
// assertion macros shared by the nonce check unit rtl
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef SHA256D_NONCE_CHECK_UNIT_ASSERT_SVH
`define SHA256D_NONCE_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SNC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("snc assertion failed");
`define SNC_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("snc forbidden condition seen");
`else
`define SNC_ASSERT(lbl, clk, rstn, prop)
`define SNC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/snc_pkg.sv
// shared types, constants and functions of the double sha-256 nonce check unit
// no dependencies
package snc_pkg;

	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 8;
	localparam int BLK_WORDS  = 16;
	localparam int ROUNDS     = 64;
	localparam int IN_DATA_W  = 4 * WORD_W;
	localparam int OUT_DATA_W = (NUM_WORDS + 1) * WORD_W;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_WORDS-1:0] state_arr_t;
	typedef word_t [BLK_WORDS-1:0] block_t;

	localparam word_t PAD_WORD = 32'h8000_0000;
	localparam word_t LEN_HDR  = 32'(80 * 8);
	localparam word_t LEN_DIG  = 32'(32 * 8);

	// register map, index = paddr[5:3]
	typedef enum logic [2:0] {
		REG_MID01 = 3'd0,
		REG_MID23 = 3'd1,
		REG_MID45 = 3'd2,
		REG_MID67 = 3'd3,
		REG_TGT01 = 3'd4,
		REG_TGT23 = 3'd5,
		REG_TGT45 = 3'd6,
		REG_TGT67 = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_CMP,
		ST_EMIT
	} snc_state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic match;
	} cmp_stat_t;

	function automatic word_t bswap(input word_t v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic state_arr_t iv_state();
		state_arr_t s;
		s[0] = 32'h6a09e667; s[1] = 32'hbb67ae85;
		s[2] = 32'h3c6ef372; s[3] = 32'ha54ff53a;
		s[4] = 32'h510e527f; s[5] = 32'h9b05688c;
		s[6] = 32'h1f83d9ab; s[7] = 32'h5be0cd19;
		return s;
	endfunction

	// round constants
	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/snc_regs.sv
// apb register file: midstate and target, eight 64-bit registers
// depends on snc_pkg
module snc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [snc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [snc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [snc_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output snc_pkg::state_arr_t             midstate,
	output snc_pkg::state_arr_t             target
);
	import snc_pkg::*;

	state_arr_t mid_q;
	state_arr_t tgt_q;
	reg_idx_t   idx;
	logic [2:0] lo_sel;
	logic [2:0] hi_sel;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign hi_sel = {paddr[4:3], 1'b0};
	assign lo_sel = {paddr[4:3], 1'b1};
	assign wr_en  = psel & penable & pwrite & pready;

	// register writes, upper half to the even word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= '0;
			tgt_q <= '0;
		end else if (wr_en) begin
			if (paddr[5]) begin
				tgt_q[hi_sel] <= pwdata[63:32];
				tgt_q[lo_sel] <= pwdata[31:0];
			end else begin
				mid_q[hi_sel] <= pwdata[63:32];
				mid_q[lo_sel] <= pwdata[31:0];
			end
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_MID01, REG_MID23, REG_MID45, REG_MID67: begin
				prdata = {mid_q[hi_sel], mid_q[lo_sel]};
			end
			REG_TGT01, REG_TGT23, REG_TGT45, REG_TGT67: begin
				prdata = {tgt_q[hi_sel], tgt_q[lo_sel]};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign midstate = mid_q;
	assign target   = tgt_q;

endmodule

FILE: rtl/snc_core.sv
// sha-256 compression engine, one round per cycle, shared by both hashes
// depends on snc_pkg
module snc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  snc_pkg::unit_ctl_t   ctl,
	input  snc_pkg::state_arr_t  init,
	input  snc_pkg::block_t      blk,
	output snc_pkg::core_stat_t  stat,
	output snc_pkg::state_arr_t  digest
);
	import snc_pkg::*;

	localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);

	state_arr_t  v_q;
	state_arr_t  init_q;
	state_arr_t  dig_q;
	block_t      w_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        fin_q;
	logic        done_q;
	word_t       t1;
	word_t       t2;
	word_t       w_new;

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	// round function and schedule word of the sliding window
	always_comb begin
		t1 = v_q[7]
			+ (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(cnt_q) + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9]
			+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == ROUND_LAST);
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == ROUND_LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// working variables, schedule window and feed-forward
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q    <= init;
			init_q <= init;
			w_q    <= blk;
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			w_q    <= {w_new, w_q[BLK_WORDS-1:1]};
		end
		if (fin_q) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				dig_q[i] <= init_q[i] + v_q[i];
			end
		end
	end

	assign stat.busy = run_q | fin_q;
	assign stat.done = done_q;
	assign digest    = dig_q;

endmodule

FILE: rtl/snc_cmp.sv
// word-serial compare of the byte-swapped digest against the target
// depends on snc_pkg
module snc_cmp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  snc_pkg::unit_ctl_t   ctl,
	input  snc_pkg::state_arr_t  digest,
	input  snc_pkg::state_arr_t  target,
	output snc_pkg::cmp_stat_t   stat
);
	import snc_pkg::*;

	logic [2:0] idx_q;
	logic       run_q;
	logic       done_q;
	logic       match_q;
	word_t      x;
	word_t      tw;

	assign x  = bswap(digest[idx_q]);
	assign tw = target[idx_q];

	// most significant word first, equal falls through to the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				idx_q <= 3'(NUM_WORDS - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (x != tw || idx_q == '0) begin
					run_q   <= 1'b0;
					done_q  <= 1'b1;
					match_q <= (x <= tw);
				end else begin
					idx_q <= idx_q - 3'd1;
				end
			end
		end
	end

	assign stat.busy  = run_q;
	assign stat.done  = done_q;
	assign stat.match = match_q;

endmodule

FILE: rtl/sha256d_nonce_check_unit.sv
// top level of the double sha-256 nonce check unit: sequencer and stream ports
// depends on snc_pkg, snc_regs, snc_core, snc_cmp and the assertion header
//
//  channel  | dir | handshake          | content
//  s_*      | in  | s_tvalid/s_tready  | tail words 0..2, nonce, tlast = last_of_range
//  m_*      | out | m_tvalid/m_tready  | nonce, digest, tuser = meets_target, tlast = scan_end
//  apb      | in  | psel & penable     | midstate and target, 64-bit registers at 8*i
//
// an item passes twice through the shared compression core (64 rounds, feed-forward,
// handoff), then through the word-serial target compare, then loads the output
// register, and the sequencer returns to idle to take the next item.
// s_tready is high only while the sequencer is idle; a finished result may wait in the
// output register while the next item is already being hashed.
// reset clears the sequencer, the valid flag and the apb registers to zero.
`include "sha256d_nonce_check_unit_assert.svh"
module sha256d_nonce_check_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// tail_word0, tail_word1, tail_word2, nonce (lowest bits first)
	input  logic [snc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// result_nonce, digest_word0 .. digest_word7 (lowest bits first)
	output logic [snc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// meets_target
	output logic                            m_tuser,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [snc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [snc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [snc_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import snc_pkg::*;

	snc_state_t  state_q;
	snc_state_t  state_d;
	state_arr_t  midstate;
	state_arr_t  target;
	state_arr_t  digest;
	state_arr_t  core_init;
	block_t      core_blk;
	block_t      blk_hdr;
	block_t      blk_dig;
	unit_ctl_t   core_ctl;
	unit_ctl_t   cmp_ctl;
	core_stat_t  core_stat;
	cmp_stat_t   cmp_stat;
	logic        in_acc;
	logic        out_load;
	logic        sel_second;
	word_t       nonce_q;
	logic        last_q;
	logic        m_valid_q;
	word_t       m_nonce_q;
	state_arr_t  m_dig_q;
	logic        m_match_q;
	logic        m_last_q;

	snc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.midstate (midstate),
		.target   (target)
	);

	snc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.init   (core_init),
		.blk    (core_blk),
		.stat   (core_stat),
		.digest (digest)
	);

	snc_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmp_ctl),
		.digest (digest),
		.target (target),
		.stat   (cmp_stat)
	);

	// message blocks of the two compressions
	always_comb begin
		blk_hdr     = '0;
		blk_hdr[0]  = s_tdata[31:0];
		blk_hdr[1]  = s_tdata[63:32];
		blk_hdr[2]  = s_tdata[95:64];
		blk_hdr[3]  = bswap(s_tdata[127:96]);
		blk_hdr[4]  = PAD_WORD;
		blk_hdr[15] = LEN_HDR;
		blk_dig     = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			blk_dig[i] = digest[i];
		end
		blk_dig[8]  = PAD_WORD;
		blk_dig[15] = LEN_DIG;
	end

	assign core_blk  = sel_second ? blk_dig : blk_hdr;
	assign core_init = sel_second ? iv_state() : midstate;
	assign in_acc    = s_tvalid & s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_HASH1;
			end
			ST_HASH1: begin
				if (core_stat.done) state_d = ST_HASH2;
			end
			ST_HASH2: begin
				if (core_stat.done) state_d = ST_CMP;
			end
			ST_CMP: begin
				if (cmp_stat.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready       = 1'b0;
		core_ctl.start = 1'b0;
		cmp_ctl.start  = 1'b0;
		sel_second     = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				core_ctl.start = s_tvalid;
			end
			ST_HASH1: begin
				sel_second     = 1'b1;
				core_ctl.start = core_stat.done;
			end
			ST_HASH2: begin
				cmp_ctl.start = core_stat.done;
			end
			ST_CMP: begin
			end
			ST_EMIT: begin
				out_load = !m_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item capture and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			nonce_q <= s_tdata[127:96];
			last_q  <= s_tlast;
		end
		if (out_load) begin
			m_nonce_q <= nonce_q;
			m_last_q  <= last_q;
			m_dig_q   <= digest;
			m_match_q <= cmp_stat.match;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_dig_q, m_nonce_q};
	assign m_tuser  = m_match_q;
	assign m_tlast  = m_last_q;

	`SNC_NEVER(a_core_restart, clk, arst_n, core_ctl.start && core_stat.busy)
	`SNC_NEVER(a_load_overwrite, clk, arst_n, out_load && m_valid_q && !m_tready)
	`SNC_ASSERT(a_cmp_after_hash, clk, arst_n, cmp_stat.done |-> state_q == ST_CMP)
	`SNC_ASSERT(a_idle_core_quiet, clk, arst_n, state_q == ST_IDLE |-> !core_stat.busy)

endmodule

FILE: tb/sha256d_nonce_check_unit_test.sv
// testbench for the double sha-256 nonce check unit: stream and apb drivers,
// an in-bench digest predictor and an in-order result scoreboard
// depends on snc_pkg and the sha256d_nonce_check_unit rtl
`timescale 1ns / 100ps
module sha256d_nonce_check_unit_test;
	import snc_pkg::*;

	localparam int TARGET_ITEMS   = 1200;
	localparam int RX_HOLD_CYCLES = 1000;
	localparam int SETTLE_CYCLES  = 160;

	// round constants, word 0 in the top bits
	localparam logic [64*32-1:0] HASH_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// standard initial hash value, word 0 in the top bits
	localparam logic [8*32-1:0] HASH_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		word_t tail0;
		word_t tail1;
		word_t tail2;
		word_t nonce;
		logic  last_of_range;
	} nonce_job_t;

	typedef struct packed {
		word_t      nonce;
		logic       meets_target;
		logic       scan_end;
		state_arr_t digest;
	} digest_result_t;

	function automatic word_t byte_rev(input word_t v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// digest predictor and in-order store of expected results
	class nonce_scoreboard;
		state_arr_t     midstate;
		state_arr_t     target;
		digest_result_t pending_results[$];
		int             errors;

		function new();
			midstate = '0;
			target   = '0;
			errors   = 0;
		endfunction

		function void write_register(reg_idx_t idx, logic [63:0] value);
			int k;
			k = (int'(idx) & 3) * 2;
			if (idx < REG_TGT01) begin
				midstate[k]     = value[63:32];
				midstate[k + 1] = value[31:0];
			end else begin
				target[k]     = value[63:32];
				target[k + 1] = value[31:0];
			end
		endfunction

		function state_arr_t compress_block(state_arr_t h, block_t blk);
			word_t w [64];
			word_t a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
			int i;
			for (i = 0; i < 16; i++)
				w[i] = blk[i];
			for (i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			a = h[0]; b = h[1]; c = h[2]; d = h[3];
			e = h[4]; f = h[5]; g = h[6]; hh = h[7];
			for (i = 0; i < 64; i++) begin
				t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
					+ HASH_K[2047 - 32*i -: 32] + w[i];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				hh = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d;
			h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
			return h;
		endfunction

		// swapped digest compared from the top word down, equal matches
		function logic at_most_target(state_arr_t dg);
			word_t x;
			int i;
			for (i = 7; i >= 0; i--) begin
				x = byte_rev(dg[i]);
				if (x < target[i])
					return 1'b1;
				if (x > target[i])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function digest_result_t double_hash(nonce_job_t job);
			block_t         blk;
			state_arr_t     first, iv;
			digest_result_t r;
			int i;
			blk    = '0;
			blk[0] = job.tail0;
			blk[1] = job.tail1;
			blk[2] = job.tail2;
			blk[3] = byte_rev(job.nonce);
			blk[4] = PAD_WORD;
			blk[15] = LEN_HDR;
			first = compress_block(midstate, blk);
			blk = '0;
			for (i = 0; i < 8; i++) begin
				blk[i] = first[i];
				iv[i]  = HASH_IV[255 - 32*i -: 32];
			end
			blk[8]  = PAD_WORD;
			blk[15] = LEN_DIG;
			r.digest       = compress_block(iv, blk);
			r.nonce        = job.nonce;
			r.meets_target = at_most_target(r.digest);
			r.scan_end     = job.last_of_range;
			return r;
		endfunction

		function void note_job(nonce_job_t job);
			pending_results.push_back(double_hash(job));
		endfunction

		function void compare_field(string name, word_t want, word_t got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch %s: expected %08h actual %08h", name, want, got);
			end
		endfunction

		function void check_result(digest_result_t got);
			digest_result_t want;
			int i;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item, nonce %08h", got.nonce);
				return;
			end
			want = pending_results.pop_front();
			compare_field("result_nonce", want.nonce, got.nonce);
			compare_field("meets_target", 32'(want.meets_target), 32'(got.meets_target));
			compare_field("scan_end", 32'(want.scan_end), 32'(got.scan_end));
			for (i = 0; i < 8; i++)
				compare_field($sformatf("digest_word%0d", i), want.digest[i], got.digest[i]);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	nonce_scoreboard sb;
	bit              quiet;
	bit              rx_hold_req;
	int              items_sent;

	sha256d_nonce_check_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// result receiver: random stalls, one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 0; n < RX_HOLD_CYCLES; n++)
					@(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 7);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		digest_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.nonce        = m_tdata[31:0];
			got.meets_target = m_tuser;
			got.scan_end     = m_tlast;
			for (int i = 0; i < 8; i++)
				got.digest[i] = m_tdata[32*(i+1) +: 32];
			sb.check_result(got);
		end
	end

	// apb write: setup cycle, access cycle, then the bus is released
	task automatic reg_write(reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_midstate(state_arr_t m);
		reg_write(REG_MID01, {m[0], m[1]});
		reg_write(REG_MID23, {m[2], m[3]});
		reg_write(REG_MID45, {m[4], m[5]});
		reg_write(REG_MID67, {m[6], m[7]});
	endtask

	task automatic set_target(state_arr_t t);
		reg_write(REG_TGT01, {t[0], t[1]});
		reg_write(REG_TGT23, {t[2], t[3]});
		reg_write(REG_TGT45, {t[4], t[5]});
		reg_write(REG_TGT67, {t[6], t[7]});
	endtask

	// offer one item, with an occasional gap before it
	task automatic send_job(nonce_job_t job);
		if (!quiet && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {job.nonce, job.tail2, job.tail1, job.tail0};
		s_tlast  <= job.last_of_range;
		do @(posedge clk); while (!s_tready);
		sb.note_job(job);
		items_sent++;
	endtask

	task automatic send_fields(word_t t0, word_t t1, word_t t2, word_t n, logic last);
		nonce_job_t job;
		job = '{tail0: t0, tail1: t1, tail2: t2, nonce: n, last_of_range: last};
		send_job(job);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic state_arr_t rand_words();
		state_arr_t v;
		for (int i = 0; i < 8; i++)
			v[i] = $urandom;
		return v;
	endfunction

	// a scan range: fixed tail, consecutive nonces, last one flagged
	task automatic send_range(int len);
		word_t t0, t1, t2, n;
		t0 = $urandom;
		t1 = $urandom;
		t2 = $urandom;
		n  = ($urandom_range(9) == 0) ? 32'hffff_fff8 : $urandom;
		for (int k = 0; k < len; k++)
			send_fields(t0, t1, t2, n + k, k == len - 1);
	endtask

	// stimulus
	initial begin : stimulus
		nonce_job_t     probe;
		digest_result_t hit;
		state_arr_t     tgt;
		state_arr_t     mid;
		int             phase;
		int             phase_end;

		sb          = new();
		quiet       = 1'b0;
		rx_hold_req = 1'b0;
		items_sent  = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: zero midstate, zero target
		send_fields('0, '0, '0, '0, 1'b0);
		send_fields('1, '1, '1, '1, 1'b1);
		send_fields($urandom, $urandom, $urandom, $urandom, 1'b0);
		drain();

		// field extremes and patterns, target at its maximum
		set_midstate(rand_words());
		set_target({8{32'hffff_ffff}});
		send_fields('0, '0, '0, '0, 1'b0);
		send_fields('1, '1, '1, '1, 1'b1);
		send_fields(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
		send_fields(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);
		send_fields(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h0102_0304, 1'b0);
		send_fields(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'hff00_00ff, 1'b0);
		send_fields(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h0000_00ff, 1'b1);
		send_fields('0, '0, '0, 32'hff00_0000, 1'b0);
		send_fields('0, '0, '0, 32'h0000_0001, 1'b0);
		send_fields('0, '0, '0, 32'h8000_0000, 1'b1);
		drain();

		// all-ones midstate, zero target: nothing matches
		set_midstate({8{32'hffff_ffff}});
		set_target('0);
		send_fields($urandom, $urandom, $urandom, $urandom, 1'b0);
		send_fields('1, '0, '1, '0, 1'b1);
		drain();

		// target equal to the swapped digest, then just below and above it
		set_midstate(rand_words());
		probe = '{tail0: $urandom, tail1: $urandom, tail2: $urandom, nonce: $urandom,
			last_of_range: 1'b1};
		hit = sb.double_hash(probe);
		for (int i = 0; i < 8; i++)
			tgt[i] = byte_rev(hit.digest[i]);
		set_target(tgt);
		send_job(probe);
		drain();
		tgt[0] = tgt[0] - 1;
		set_target(tgt);
		send_job(probe);
		drain();
		tgt[0] = tgt[0] + 2;
		set_target(tgt);
		send_job(probe);
		drain();
		// top word equal, lower words decide
		for (int i = 0; i < 7; i++)
			tgt[i] = '0;
		set_target(tgt);
		send_job(probe);
		drain();

		// random phases, each with its own register setting
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			case (phase % 4)
				0: mid = rand_words();
				1: mid = '0;
				2: mid = {8{32'hffff_ffff}};
				default: mid = rand_words();
			endcase
			case (phase % 5)
				0: tgt = rand_words();
				1: tgt = {8{32'hffff_ffff}};
				2: tgt = '0;
				3: begin
					tgt = rand_words();
					tgt[7] = 32'h8000_0000 ^ ($urandom & 32'h00ff_ffff);
				end
				default: tgt = rand_words();
			endcase
			set_midstate(mid);
			set_target(tgt);
			quiet = (phase == 2);
			if (phase == 1)
				rx_hold_req = 1'b1;
			phase_end = items_sent + 150;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 80)
					send_range($urandom_range(1, 16));
				else
					send_fields($urandom, $urandom, $urandom, $urandom,
						1'($urandom_range(1)));
			end
			drain();
			phase++;
		end
		quiet = 1'b0;

		// let anything late show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
